FILE: sv/moi_pkg.sv
// ----------------------------------------------------------------------------
// moi_pkg
// Shared types, constants and tables of the mecanum odometry integrator.
// ----------------------------------------------------------------------------
package moi_pkg;

  localparam int CORDIC_STEPS_DEF = 14;
  localparam int ATAN_LEN         = 24;
  localparam int ATAN_IW          = 5;

  localparam int SPEED_W = 16;
  localparam int YAW_W   = 16;
  localparam int DT_W    = 16;
  localparam int POSE_W  = 32;
  localparam int VEL_W   = 16;

  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  localparam int SUM_W   = 19;   // four wheel speeds, signed sum
  localparam int XW      = 27;   // CORDIC vector and Q.16 velocities
  localparam int ZW      = 29;   // CORDIC angle, Q.24
  localparam int MA_W    = 33;   // shared multiplier operand A
  localparam int MB_W    = 25;   // shared multiplier operand B
  localparam int MP_W    = MA_W + MB_W;

  localparam logic [15:0] WHEEL_RADIUS_RST = 16'd6658;
  localparam logic [15:0] TURN_GAIN_RST    = 16'd44677;

  localparam logic signed [ZW-1:0]   PI_Q24      = 29'sd52707179;
  localparam logic signed [ZW-1:0]   HALF_PI_Q24 = 29'sd26353589;
  localparam logic signed [MB_W-1:0] INV_GAIN_Q24 = 25'sd10188014;

  typedef enum logic [1:0] {
    REG_WHEEL_RADIUS = 2'd0,
    REG_TURN_GAIN    = 2'd1,
    REG_START_X      = 2'd2,
    REG_START_Y      = 2'd3
  } moi_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_VX,
    ST_VY,
    ST_RG,
    ST_ROT,
    ST_ROTW,
    ST_CORD,
    ST_FLIP,
    ST_WX,
    ST_WY,
    ST_PX,
    ST_PY,
    ST_PH,
    ST_HD,
    ST_DONE
  } moi_state_t;

  typedef struct packed {
    logic [15:0]        wheel_radius;
    logic [15:0]        turn_gain;
    logic               wr_x;
    logic               wr_y;
    logic signed [31:0] wdata;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic step;
    logic fix_sign;
  } cordic_ctl_t;

  typedef struct packed {
    logic signed [SPEED_W-1:0] speed_front_left;
    logic signed [SPEED_W-1:0] speed_front_right;
    logic signed [SPEED_W-1:0] speed_back_left;
    logic signed [SPEED_W-1:0] speed_back_right;
    logic signed [YAW_W-1:0]   yaw_angle;
    logic [DT_W-1:0]           time_step;
  } in_item_t;

  typedef struct packed {
    logic signed [POSE_W-1:0] position_x;
    logic signed [POSE_W-1:0] position_y;
    logic signed [POSE_W-1:0] heading;
    logic signed [VEL_W-1:0]  world_vel_x;
    logic signed [VEL_W-1:0]  world_vel_y;
    logic signed [VEL_W-1:0]  turn_rate;
  } out_item_t;

  // Arctangent of 2^-i in Q.24.
  function automatic logic [23:0] atan_q24(input logic [ATAN_IW-1:0] idx);
    logic [23:0] v;
    case (idx)
      5'd0:    v = 24'd13176795;
      5'd1:    v = 24'd7778716;
      5'd2:    v = 24'd4110060;
      5'd3:    v = 24'd2086331;
      5'd4:    v = 24'd1047214;
      5'd5:    v = 24'd524117;
      5'd6:    v = 24'd262123;
      5'd7:    v = 24'd131069;
      5'd8:    v = 24'd65536;
      5'd9:    v = 24'd32768;
      5'd10:   v = 24'd16384;
      5'd11:   v = 24'd8192;
      5'd12:   v = 24'd4096;
      5'd13:   v = 24'd2048;
      5'd14:   v = 24'd1024;
      5'd15:   v = 24'd512;
      5'd16:   v = 24'd256;
      5'd17:   v = 24'd128;
      5'd18:   v = 24'd64;
      5'd19:   v = 24'd32;
      5'd20:   v = 24'd16;
      5'd21:   v = 24'd8;
      5'd22:   v = 24'd4;
      5'd23:   v = 24'd2;
      default: v = 24'd0;
    endcase
    return v;
  endfunction

endpackage

FILE: sv/moi_in_if.sv
// ----------------------------------------------------------------------------
// moi_in_if
// Input channel: wheel speeds, yaw and time step with valid/ready.
// ----------------------------------------------------------------------------
interface moi_in_if;
  logic                                      valid;
  logic                                      ready;
  logic signed [moi_pkg::SPEED_W-1:0]        speed_front_left;
  logic signed [moi_pkg::SPEED_W-1:0]        speed_front_right;
  logic signed [moi_pkg::SPEED_W-1:0]        speed_back_left;
  logic signed [moi_pkg::SPEED_W-1:0]        speed_back_right;
  logic signed [moi_pkg::YAW_W-1:0]          yaw_angle;
  logic [moi_pkg::DT_W-1:0]                  time_step;

  modport source (
    output valid, speed_front_left, speed_front_right, speed_back_left,
           speed_back_right, yaw_angle, time_step,
    input  ready
  );

  modport sink (
    input  valid, speed_front_left, speed_front_right, speed_back_left,
           speed_back_right, yaw_angle, time_step,
    output ready
  );
endinterface

FILE: sv/moi_out_if.sv
// ----------------------------------------------------------------------------
// moi_out_if
// Result channel: pose and velocities with valid/ready.
// ----------------------------------------------------------------------------
interface moi_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [moi_pkg::POSE_W-1:0]   position_x;
  logic signed [moi_pkg::POSE_W-1:0]   position_y;
  logic signed [moi_pkg::POSE_W-1:0]   heading;
  logic signed [moi_pkg::VEL_W-1:0]    world_vel_x;
  logic signed [moi_pkg::VEL_W-1:0]    world_vel_y;
  logic signed [moi_pkg::VEL_W-1:0]    turn_rate;

  modport source (
    output valid, position_x, position_y, heading, world_vel_x, world_vel_y,
           turn_rate,
    input  ready
  );

  modport sink (
    input  valid, position_x, position_y, heading, world_vel_x, world_vel_y,
           turn_rate,
    output ready
  );
endinterface

FILE: sv/moi_regs.sv
// ----------------------------------------------------------------------------
// moi_regs
// APB register file: wheel radius, turn gain and start pose.
// ----------------------------------------------------------------------------
module moi_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [moi_pkg::ADDR_W-1:0]    paddr,
  input  logic [moi_pkg::DATA_W-1:0]    pwdata,
  output logic [moi_pkg::DATA_W-1:0]    prdata,
  output logic                          pready,
  output moi_pkg::cfg_t                 cfg
);

  logic [15:0]        wheel_radius_r;
  logic [15:0]        turn_gain_r;
  logic signed [31:0] start_x_r;
  logic signed [31:0] start_y_r;
  logic               wr_en;
  moi_pkg::moi_reg_t  idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = moi_pkg::moi_reg_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wheel_radius_r <= moi_pkg::WHEEL_RADIUS_RST;
      turn_gain_r    <= moi_pkg::TURN_GAIN_RST;
      start_x_r      <= '0;
      start_y_r      <= '0;
    end else if (wr_en) begin
      unique case (idx)
        moi_pkg::REG_WHEEL_RADIUS: wheel_radius_r <= pwdata[15:0];
        moi_pkg::REG_TURN_GAIN:    turn_gain_r    <= pwdata[15:0];
        moi_pkg::REG_START_X:      start_x_r      <= $signed(pwdata);
        moi_pkg::REG_START_Y:      start_y_r      <= $signed(pwdata);
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      moi_pkg::REG_WHEEL_RADIUS: prdata = {16'd0, wheel_radius_r};
      moi_pkg::REG_TURN_GAIN:    prdata = {16'd0, turn_gain_r};
      moi_pkg::REG_START_X:      prdata = start_x_r;
      moi_pkg::REG_START_Y:      prdata = start_y_r;
      default:                   prdata = '0;
    endcase
  end

  always_comb begin
    cfg.wheel_radius = wheel_radius_r;
    cfg.turn_gain    = turn_gain_r;
    cfg.wr_x         = wr_en && (idx == moi_pkg::REG_START_X);
    cfg.wr_y         = wr_en && (idx == moi_pkg::REG_START_Y);
    cfg.wdata        = $signed(pwdata);
  end

endmodule

FILE: sv/moi_mul.sv
// ----------------------------------------------------------------------------
// moi_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module moi_mul (
  input  logic                              clk,
  input  logic signed [moi_pkg::MA_W-1:0]   a,
  input  logic signed [moi_pkg::MB_W-1:0]   b,
  output logic signed [moi_pkg::MP_W-1:0]   p_r
);

  logic signed [moi_pkg::MP_W-1:0] p_nxt;

  assign p_nxt = moi_pkg::MP_W'(a) * moi_pkg::MP_W'(b);

  always_ff @(posedge clk) begin
    p_r <= p_nxt;
  end

endmodule

FILE: sv/moi_cordic.sv
// ----------------------------------------------------------------------------
// moi_cordic
// Rotation-mode CORDIC with quadrant fold; one micro-rotation per step cycle.
// ----------------------------------------------------------------------------
module moi_cordic #(
  parameter int CORDIC_STEPS = moi_pkg::CORDIC_STEPS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  moi_pkg::cordic_ctl_t              ctl,
  input  logic signed [moi_pkg::XW-1:0]     x_in,
  input  logic signed [moi_pkg::XW-1:0]     y_in,
  input  logic signed [moi_pkg::YAW_W-1:0]  yaw,
  output logic signed [moi_pkg::XW-1:0]     x_out,
  output logic signed [moi_pkg::XW-1:0]     y_out,
  output logic                              last
);

  localparam int CW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
  localparam int ZW = moi_pkg::ZW;
  localparam int XW = moi_pkg::XW;

  logic signed [XW-1:0] x_r, x_nxt;
  logic signed [XW-1:0] y_r, y_nxt;
  logic signed [ZW-1:0] z_r, z_nxt;
  logic                 flip_r, flip_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;

  logic signed [ZW-1:0] z0;
  logic signed [XW-1:0] xs, ys;
  logic signed [ZW-1:0] atan_v;

  assign z0     = {{(ZW - moi_pkg::YAW_W - 11){yaw[moi_pkg::YAW_W-1]}}, yaw, 11'd0};
  assign xs     = x_r >>> cnt_r;
  assign ys     = y_r >>> cnt_r;
  assign atan_v = $signed({{(ZW - 24){1'b0}},
                           moi_pkg::atan_q24(moi_pkg::ATAN_IW'(cnt_r))});
  assign last   = (cnt_r == CW'(CORDIC_STEPS - 1));

  always_comb begin
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    flip_nxt = flip_r;
    cnt_nxt  = cnt_r;
    if (ctl.load) begin
      x_nxt   = x_in;
      y_nxt   = y_in;
      cnt_nxt = '0;
      // fold angles beyond a quarter turn and flip the result
      if (z0 > moi_pkg::HALF_PI_Q24) begin
        z_nxt    = z0 - moi_pkg::PI_Q24;
        flip_nxt = 1'b1;
      end else if (z0 < -moi_pkg::HALF_PI_Q24) begin
        z_nxt    = z0 + moi_pkg::PI_Q24;
        flip_nxt = 1'b1;
      end else begin
        z_nxt    = z0;
        flip_nxt = 1'b0;
      end
    end else if (ctl.step) begin
      if (!z_r[ZW-1]) begin
        x_nxt = x_r - ys;
        y_nxt = y_r + xs;
        z_nxt = z_r - atan_v;
      end else begin
        x_nxt = x_r + ys;
        y_nxt = y_r - xs;
        z_nxt = z_r + atan_v;
      end
      cnt_nxt = cnt_r + CW'(1);
    end else if (ctl.fix_sign && flip_r) begin
      x_nxt = -x_r;
      y_nxt = -y_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      flip_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      flip_r <= flip_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
  end

  assign x_out = x_r;
  assign y_out = y_r;

endmodule

FILE: sv/moi_core.sv
// ----------------------------------------------------------------------------
// moi_core
// Sequencer and datapath: kinematics, rotation, scaling and pose update
// through one shared multiplier.
// ----------------------------------------------------------------------------
module moi_core #(
  parameter int CORDIC_STEPS = moi_pkg::CORDIC_STEPS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  moi_pkg::cfg_t       cfg,
  input  logic                in_valid,
  input  moi_pkg::in_item_t   in_item,
  output logic                in_ready,
  input  logic                out_free,
  output logic                res_valid,
  output moi_pkg::out_item_t  res
);

  localparam int XW    = moi_pkg::XW;
  localparam int SW    = moi_pkg::SUM_W;
  localparam int MA_W  = moi_pkg::MA_W;
  localparam int MB_W  = moi_pkg::MB_W;
  localparam int MP_W  = moi_pkg::MP_W;

  moi_pkg::moi_state_t state_r, state_nxt;

  logic signed [SW-1:0]    sum_x_r, sum_y_r, sum_r_r;
  logic signed [moi_pkg::YAW_W-1:0] yaw_r;
  logic [moi_pkg::DT_W-1:0] dt_r;
  logic signed [XW-1:0]    vx_r, vy_r, rot_r, wx_r, wy_r;
  logic signed [31:0]      acc_x_r, acc_y_r, acc_h_r;

  logic signed [MA_W-1:0]  mul_a;
  logic signed [MB_W-1:0]  mul_b;
  logic signed [MP_W-1:0]  p_r;
  moi_pkg::cordic_ctl_t    cctl;
  logic signed [XW-1:0]    cx, cy;
  logic                    c_last;

  logic signed [SW-1:0]    fl, fr, bl, br;
  logic signed [MP_W-1:0]  p_rnd10, p_rnd16, p_rnd24;
  logic signed [XW-1:0]    q10, q16, q24;

  logic ld_vx, ld_vy, ld_rot, ld_wx, ld_wy, upd_x, upd_y, upd_h;

  function automatic logic signed [31:0] acc_add(input logic signed [31:0] acc,
                                                 input logic signed [XW-1:0] inc);
    logic signed [32:0] s;
    s = {acc[31], acc} + {{(33 - XW){inc[XW-1]}}, inc};
    if (s[32] != s[31]) begin
      return s[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end
    return s[31:0];
  endfunction

  function automatic logic signed [15:0] vel_q8(input logic signed [XW-1:0] v);
    logic signed [XW:0]   t;
    logic signed [XW-8:0] s;
    t = {v[XW-1], v} + (XW + 1)'(128);
    s = t[XW:8];
    if (s > (XW - 7)'(32767)) begin
      return 16'sh7fff;
    end else if (s < -(XW - 7)'(32768)) begin
      return 16'sh8000;
    end
    return s[15:0];
  endfunction

  moi_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (p_r)
  );

  moi_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (cctl),
    .x_in  (vx_r),
    .y_in  (vy_r),
    .yaw   (yaw_r),
    .x_out (cx),
    .y_out (cy),
    .last  (c_last)
  );

  assign fl = SW'(in_item.speed_front_left);
  assign fr = SW'(in_item.speed_front_right);
  assign bl = SW'(in_item.speed_back_left);
  assign br = SW'(in_item.speed_back_right);

  // round half up, then floor shift
  assign p_rnd10 = p_r + MP_W'(1 << 9);
  assign p_rnd16 = p_r + MP_W'(1 << 15);
  assign p_rnd24 = p_r + MP_W'(1 << 23);
  assign q10     = $signed(p_rnd10[XW+9:10]);
  assign q16     = $signed(p_rnd16[XW+15:16]);
  assign q24     = $signed(p_rnd24[XW+23:24]);

  assign in_ready = (state_r == moi_pkg::ST_IDLE);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      moi_pkg::ST_IDLE: if (in_valid) state_nxt = moi_pkg::ST_VX;
      moi_pkg::ST_VX:   state_nxt = moi_pkg::ST_VY;
      moi_pkg::ST_VY:   state_nxt = moi_pkg::ST_RG;
      moi_pkg::ST_RG:   state_nxt = moi_pkg::ST_ROT;
      moi_pkg::ST_ROT:  state_nxt = moi_pkg::ST_ROTW;
      moi_pkg::ST_ROTW: state_nxt = moi_pkg::ST_CORD;
      moi_pkg::ST_CORD: if (c_last) state_nxt = moi_pkg::ST_FLIP;
      moi_pkg::ST_FLIP: state_nxt = moi_pkg::ST_WX;
      moi_pkg::ST_WX:   state_nxt = moi_pkg::ST_WY;
      moi_pkg::ST_WY:   state_nxt = moi_pkg::ST_PX;
      moi_pkg::ST_PX:   state_nxt = moi_pkg::ST_PY;
      moi_pkg::ST_PY:   state_nxt = moi_pkg::ST_PH;
      moi_pkg::ST_PH:   state_nxt = moi_pkg::ST_HD;
      moi_pkg::ST_HD:   state_nxt = moi_pkg::ST_DONE;
      moi_pkg::ST_DONE: if (out_free) state_nxt = moi_pkg::ST_IDLE;
      default:          state_nxt = moi_pkg::ST_IDLE;
    endcase
  end

  // outputs: multiplier operands, CORDIC control, register loads
  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    cctl      = '0;
    ld_vx     = 1'b0;
    ld_vy     = 1'b0;
    ld_rot    = 1'b0;
    ld_wx     = 1'b0;
    ld_wy     = 1'b0;
    upd_x     = 1'b0;
    upd_y     = 1'b0;
    upd_h     = 1'b0;
    res_valid = 1'b0;
    unique case (state_r)
      moi_pkg::ST_VX: begin
        mul_a = $signed({{(MA_W - 16){1'b0}}, cfg.wheel_radius});
        mul_b = MB_W'(sum_x_r);
      end
      moi_pkg::ST_VY: begin
        ld_vx = 1'b1;
        mul_a = $signed({{(MA_W - 16){1'b0}}, cfg.wheel_radius});
        mul_b = MB_W'(sum_y_r);
      end
      moi_pkg::ST_RG: begin
        ld_vy = 1'b1;
        mul_a = $signed({{(MA_W - 16){1'b0}}, cfg.wheel_radius});
        mul_b = $signed({{(MB_W - 16){1'b0}}, cfg.turn_gain});
      end
      moi_pkg::ST_ROT: begin
        cctl.load = 1'b1;
        mul_a = $signed({1'b0, p_r[31:0]});
        mul_b = MB_W'(sum_r_r);
      end
      moi_pkg::ST_ROTW: ld_rot = 1'b1;
      moi_pkg::ST_CORD: cctl.step = 1'b1;
      moi_pkg::ST_FLIP: cctl.fix_sign = 1'b1;
      moi_pkg::ST_WX: begin
        mul_a = MA_W'(cx);
        mul_b = moi_pkg::INV_GAIN_Q24;
      end
      moi_pkg::ST_WY: begin
        ld_wx = 1'b1;
        mul_a = MA_W'(cy);
        mul_b = moi_pkg::INV_GAIN_Q24;
      end
      moi_pkg::ST_PX: begin
        ld_wy = 1'b1;
        mul_a = MA_W'(wx_r);
        mul_b = $signed({{(MB_W - 16){1'b0}}, dt_r});
      end
      moi_pkg::ST_PY: begin
        upd_x = 1'b1;
        mul_a = MA_W'(wy_r);
        mul_b = $signed({{(MB_W - 16){1'b0}}, dt_r});
      end
      moi_pkg::ST_PH: begin
        upd_y = 1'b1;
        mul_a = MA_W'(rot_r);
        mul_b = $signed({{(MB_W - 16){1'b0}}, dt_r});
      end
      moi_pkg::ST_HD:   upd_h = 1'b1;
      moi_pkg::ST_DONE: res_valid = out_free;
      default: ;
    endcase
  end

  always_comb begin
    res.position_x  = acc_x_r;
    res.position_y  = acc_y_r;
    res.heading     = acc_h_r;
    res.world_vel_x = vel_q8(wx_r);
    res.world_vel_y = vel_q8(wy_r);
    res.turn_rate   = vel_q8(rot_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= moi_pkg::ST_IDLE;
      acc_x_r <= '0;
      acc_y_r <= '0;
      acc_h_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg.wr_x) begin
        acc_x_r <= cfg.wdata;
      end else if (upd_x) begin
        acc_x_r <= acc_add(acc_x_r, q16);
      end
      if (cfg.wr_y) begin
        acc_y_r <= cfg.wdata;
      end else if (upd_y) begin
        acc_y_r <= acc_add(acc_y_r, q16);
      end
      if (upd_h) begin
        acc_h_r <= acc_add(acc_h_r, q16);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      sum_x_r <= fl + fr + bl + br;
      sum_y_r <= -fl + fr + bl - br;
      sum_r_r <= -fl + fr - bl + br;
      yaw_r   <= in_item.yaw_angle;
      dt_r    <= in_item.time_step;
    end
    if (ld_vx)  vx_r  <= q10;
    if (ld_vy)  vy_r  <= q10;
    if (ld_rot) rot_r <= q24;
    if (ld_wx)  wx_r  <= q24;
    if (ld_wy)  wy_r  <= q24;
  end

endmodule

FILE: sv/mecanum_odometry_integrator.sv
// ----------------------------------------------------------------------------
// mecanum_odometry_integrator
// Mecanum forward kinematics, CORDIC yaw rotation and saturating pose
// integration over one shared multiplier and one CORDIC stage.
//
//   channel   direction  handshake            payload
//   in_chan   input      valid/ready          4 wheel speeds, yaw, time step
//   out_chan  output     valid/ready          pose x/y/heading, velocities
//   APB       input      psel/penable/pready  wheel_radius, turn_gain, start
//
// After the input transfer the sequencer runs nine multiplier passes, one
// CORDIC micro-rotation per cycle, and the product drain, sign fix, heading
// update and hand-off states before the result turns valid. A new input is
// taken only once the result is in the output register. in_chan.ready is
// high only while the sequencer idles. A finished result waits in the output
// register; the sequencer holds in its last state while that register is still
// full. Synchronous active-low reset restores register defaults and clears the
// pose.
// ----------------------------------------------------------------------------
module mecanum_odometry_integrator #(
  parameter int CORDIC_STEPS = moi_pkg::CORDIC_STEPS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  moi_in_if.sink                      in_chan,
  moi_out_if.source                   out_chan,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [moi_pkg::ADDR_W-1:0]  paddr,
  input  logic [moi_pkg::DATA_W-1:0]  pwdata,
  output logic [moi_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  moi_pkg::cfg_t      cfg;
  moi_pkg::in_item_t  in_item;
  moi_pkg::out_item_t res;
  moi_pkg::out_item_t out_data_r;
  logic               out_valid_r;
  logic               out_free;
  logic               res_valid;
  logic               in_ready;

  moi_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  always_comb begin
    in_item.speed_front_left  = in_chan.speed_front_left;
    in_item.speed_front_right = in_chan.speed_front_right;
    in_item.speed_back_left   = in_chan.speed_back_left;
    in_item.speed_back_right  = in_chan.speed_back_right;
    in_item.yaw_angle         = in_chan.yaw_angle;
    in_item.time_step         = in_chan.time_step;
  end

  assign in_chan.ready = in_ready;

  moi_core #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_chan.valid),
    .in_item   (in_item),
    .in_ready  (in_ready),
    .out_free  (out_free),
    .res_valid (res_valid),
    .res       (res)
  );

  // output register frees up on the same cycle its transfer completes
  assign out_free = !out_valid_r || out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_data_r <= res;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.position_x  = out_data_r.position_x;
  assign out_chan.position_y  = out_data_r.position_y;
  assign out_chan.heading     = out_data_r.heading;
  assign out_chan.world_vel_x = out_data_r.world_vel_x;
  assign out_chan.world_vel_y = out_data_r.world_vel_y;
  assign out_chan.turn_rate   = out_data_r.turn_rate;

endmodule
